>>> src/prect_pkg.sv
// ----------------------------------------------------------------------------
// Placement rectangle adjust: shared definitions
// Fixed-point widths, register indexes, mode codes and divider sizing.
// ----------------------------------------------------------------------------
package prect_pkg;

  localparam int Q_W     = 32;          // Q16.16 word
  localparam int Q_FRAC  = 16;
  localparam int DIV_QB  = Q_W - 1;     // quotient bits below the saturation point
  localparam int ROT_W   = 25;
  localparam int CNT_W   = 16;
  localparam int DELTA_W = 26;
  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int CFG_IDX_W = 3;

  localparam int TARGET_SLOTS_DEF = 16;

  localparam logic [26:0] FULL_TURN = 27'd23592960;   // 360 degrees, Q16.16

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADJUST_MODE    = 3'd0,
    CFG_APPLY_ALL      = 3'd1,
    CFG_ROTATION_DELTA = 3'd2,
    CFG_PARAM_A        = 3'd3,
    CFG_PARAM_B        = 3'd4,
    CFG_PARAM_C        = 3'd5,
    CFG_PARAM_D        = 3'd6
  } cfg_idx_t;

  localparam logic [2:0] MODE_SCALE  = 3'd0;
  localparam logic [2:0] MODE_CROP   = 3'd1;
  localparam logic [2:0] MODE_EXTEND = 3'd2;
  localparam logic [2:0] MODE_FIT    = 3'd3;
  localparam logic [2:0] MODE_FILL   = 3'd4;

endpackage

>>> src/prect_div.sv
// ----------------------------------------------------------------------------
// Placement rectangle adjust: pipelined divider
// Computes floor(num * 2^16 / den) for a positive num and den, one quotient
// bit per stage. Only valid when the quotient is below 2^31.
// ----------------------------------------------------------------------------
module prect_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [prect_pkg::DIV_QB-1:0] num_i,
  input  logic [prect_pkg::DIV_QB-1:0] den_i,
  output logic [prect_pkg::DIV_QB-1:0] quot_o
);
  import prect_pkg::*;

  logic [DIV_QB-1:0] rem_r  [DIV_QB];
  logic [DIV_QB-1:0] bits_r [DIV_QB];
  logic [DIV_QB-1:0] den_r  [DIV_QB];
  logic [DIV_QB-1:0] quot_r [DIV_QB];

  logic [DIV_QB-1:0] rem_nxt  [DIV_QB];
  logic [DIV_QB-1:0] bits_nxt [DIV_QB];
  logic [DIV_QB-1:0] quot_nxt [DIV_QB];

  for (genvar g = 0; g < DIV_QB; g++) begin : g_step
    logic [DIV_QB-1:0] rem_in;
    logic [DIV_QB-1:0] bits_in;
    logic [DIV_QB-1:0] den_in;
    logic [DIV_QB-1:0] quot_in;
    logic [DIV_QB:0]   trial;
    logic              ge;

    if (g == 0) begin : g_first
      // upper dividend bits are already below den when the quotient fits
      assign rem_in  = DIV_QB'(num_i >> (DIV_QB - Q_FRAC));
      assign bits_in = DIV_QB'(num_i << Q_FRAC);
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign bits_in = bits_r[g-1];
      assign den_in  = den_r[g-1];
      assign quot_in = quot_r[g-1];
    end

    assign trial       = {rem_in, bits_in[DIV_QB-1]};
    assign ge          = trial >= {1'b0, den_in};
    assign rem_nxt[g]  = ge ? DIV_QB'(trial - {1'b0, den_in}) : trial[DIV_QB-1:0];
    assign bits_nxt[g] = {bits_in[DIV_QB-2:0], 1'b0};
    assign quot_nxt[g] = {quot_in[DIV_QB-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt[g];
        bits_r[g] <= bits_nxt[g];
        den_r[g]  <= den_in;
        quot_r[g] <= quot_nxt[g];
      end
    end
  end

  assign quot_o = quot_r[DIV_QB-1];

endmodule

>>> src/placement_rect_adjust_core.sv
// ----------------------------------------------------------------------------
// Placement rectangle adjust core
// Targets placements by page table or all-mode, applies scale, crop, extend,
// fit or fill, advances rotation and counts modified placements.
// ----------------------------------------------------------------------------
// One transaction per cycle is accepted while in_tready is high; in_tready
// drops only when stage 5 holds a result and the skid entry is full. A
// placement's result reaches out_tdata through 36 registers: one input stage,
// 31 stages of the bit-per-stage fit/fill divider, one select stage, one
// multiply stage, one round-and-saturate stage and the output register.
// Table loads take effect for the next transaction and produce no result.
// A two-entry output buffer keeps the pipe moving until the skid entry fills.
module placement_rect_adjust_core
  import prect_pkg::*;
#(
  parameter int TARGET_SLOTS = prect_pkg::TARGET_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [prect_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prect_pkg::Q_W-1:0]     cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: slot[3:0] slot_enable[4] page_index[20:5] page_blank[21] in_x[53:22]
  //        in_y[85:54] in_width[117:86] in_height[149:118] in_scale[181:150]
  //        in_rotation[206:182] zero[207]
  input  logic [207:0]                  in_tdata,
  input  logic                          in_tuser,   // cmd
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata: was_targeted[0] out_x[32:1] out_y[64:33] out_width[96:65]
  //        out_height[128:97] out_scale[160:129] out_rotation[185:161]
  //        zero_area[186] modified_total[202:187] zero[207:203]
  output logic [207:0]                  out_tdata
);

  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;

  typedef struct packed {
    logic        hit;
    logic [31:0] x, y, w, h, sc;
    logic [24:0] rot;
    logic [15:0] cnt;
  } st1_t;

  typedef struct packed {
    logic        hit, crop_ok, fit_ok, ovx, ovy;
    logic [31:0] x, y, w, h, sc;
    logic [32:0] sum_x, sum_y;
    logic [33:0] sum_w, sum_h;
    logic [24:0] rot;
    logic [26:0] rot_t;
    logic [15:0] cnt;
  } st2_t;

  typedef struct packed {
    logic        hit, zero, mul_sel;
    logic [31:0] fa, fb, fc;
    logic [31:0] w, h, sc;
    logic [31:0] x_o, y_o, w_o, h_o;
    logic [24:0] rot;
    logic [15:0] cnt;
  } st3_t;

  typedef struct packed {
    logic        hit, zero, mul_sel;
    logic [63:0] pw, ph, ps;
    logic [31:0] x_o, y_o, w_o, h_o, sc;
    logic [24:0] rot;
    logic [15:0] cnt;
  } st4_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] x, y, w, h, sc;
    logic [24:0] rot;
    logic        zero;
    logic [15:0] cnt;
  } res_t;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    if (v[32] == v[31]) return v[31:0];
    return v[32] ? QMIN : QMAX;
  endfunction

  function automatic logic [31:0] sat34(input logic [33:0] v);
    if (v[33] == v[32] && v[32] == v[31]) return v[31:0];
    return v[33] ? QMIN : QMAX;
  endfunction

  // round half up, drop 16 fraction bits, saturate
  function automatic logic [31:0] qround(input logic [63:0] p);
    logic [63:0] r;
    r = p + 64'd32768;
    if (r[63:47] == {17{r[47]}}) return r[47:16];
    return r[63] ? QMIN : QMAX;
  endfunction

  function automatic logic [31:0] smin(input logic [31:0] a, input logic [31:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  // ---------------- configuration ----------------
  logic [2:0]         adjust_mode_r;
  logic               apply_all_r;
  logic [DELTA_W-1:0] rotation_delta_r;
  logic [31:0]        param_a_r, param_b_r, param_c_r, param_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adjust_mode_r    <= MODE_SCALE;
      apply_all_r      <= 1'b1;
      rotation_delta_r <= '0;
      param_a_r        <= '0;
      param_b_r        <= '0;
      param_c_r        <= '0;
      param_d_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ADJUST_MODE:    adjust_mode_r    <= cfg_wdata[2:0];
        CFG_APPLY_ALL:      apply_all_r      <= cfg_wdata[0];
        CFG_ROTATION_DELTA: rotation_delta_r <= cfg_wdata[DELTA_W-1:0];
        CFG_PARAM_A:        param_a_r        <= cfg_wdata;
        CFG_PARAM_B:        param_b_r        <= cfg_wdata;
        CFG_PARAM_C:        param_c_r        <= cfg_wdata;
        CFG_PARAM_D:        param_d_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- input fields ----------------
  logic              in_cmd, in_slot_enable, in_page_blank;
  logic [SLOT_W-1:0] in_slot;
  logic [PAGE_W-1:0] in_page_index;
  logic [31:0]       in_x, in_y, in_width, in_height, in_scale;
  logic [ROT_W-1:0]  in_rotation;

  assign in_cmd         = in_tuser;
  assign in_slot        = in_tdata[3:0];
  assign in_slot_enable = in_tdata[4];
  assign in_page_index  = in_tdata[20:5];
  assign in_page_blank  = in_tdata[21];
  assign in_x           = in_tdata[53:22];
  assign in_y           = in_tdata[85:54];
  assign in_width       = in_tdata[117:86];
  assign in_height      = in_tdata[149:118];
  assign in_scale       = in_tdata[181:150];
  assign in_rotation    = in_tdata[206:182];

  // ---------------- flow control ----------------
  logic pipe_en, in_fire;
  logic v1_r, v3_r, v4_r, v5_r;
  logic vd_r [DIV_QB];
  logic out_v_r, skid_v_r;
  res_t out_r, skid_r;

  assign pipe_en   = !v5_r || !skid_v_r;
  assign in_tready = pipe_en;
  assign in_fire   = in_tvalid && in_tready;

  // ---------------- target table and count ----------------
  logic [PAGE_W-1:0] tgt_page_r  [TARGET_SLOTS];
  logic              tgt_valid_r [TARGET_SLOTS];
  logic [CNT_W-1:0]  modified_count_r, modified_count_nxt;
  logic              hit_nxt, match;

  always_comb begin
    match = 1'b0;
    for (int i = 0; i < TARGET_SLOTS; i++) begin
      if (tgt_valid_r[i] && tgt_page_r[i] == in_page_index) match = 1'b1;
    end
    hit_nxt = apply_all_r || (!in_page_blank && match);
    modified_count_nxt = modified_count_r;
    if (hit_nxt && modified_count_r != '1) modified_count_nxt = modified_count_r + 1'b1;
  end

  for (genvar g = 0; g < TARGET_SLOTS; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tgt_valid_r[g] <= 1'b0;
      end else if (in_fire && !in_cmd && 32'(in_slot) == g) begin
        tgt_valid_r[g] <= in_slot_enable;
      end
    end

    always_ff @(posedge clk) begin
      if (in_fire && !in_cmd && 32'(in_slot) == g) tgt_page_r[g] <= in_page_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modified_count_r <= '0;
    end else if (in_fire && in_cmd) begin
      modified_count_r <= modified_count_nxt;
    end
  end

  // ---------------- stage 1: registered input ----------------
  st1_t p1_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p1_r.hit <= hit_nxt;
      p1_r.x   <= in_x;
      p1_r.y   <= in_y;
      p1_r.w   <= in_width;
      p1_r.h   <= in_height;
      p1_r.sc  <= in_scale;
      p1_r.rot <= in_rotation;
      p1_r.cnt <= modified_count_nxt;
    end
  end

  // ---------------- stage 2: sums, rotation, divider setup ----------------
  st2_t st2_nxt;
  logic signed [31:0] pa_s, pb_s, pc_s, pd_s, w1_s, h1_s, x1_s, y1_s;

  assign pa_s = $signed(param_a_r);
  assign pb_s = $signed(param_b_r);
  assign pc_s = $signed(param_c_r);
  assign pd_s = $signed(param_d_r);
  assign x1_s = $signed(p1_r.x);
  assign y1_s = $signed(p1_r.y);
  assign w1_s = $signed(p1_r.w);
  assign h1_s = $signed(p1_r.h);

  always_comb begin
    st2_nxt.hit     = p1_r.hit;
    st2_nxt.crop_ok = (pc_s > 0) && (pd_s > 0);
    st2_nxt.fit_ok  = (pa_s > 0) && (pb_s > 0) && (w1_s > 0) && (h1_s > 0);
    // quotient reaches 2^31 when a >= w * 2^15
    st2_nxt.ovx = {16'b0, param_a_r[30:0]} >= {1'b0, p1_r.w[30:0], 15'b0};
    st2_nxt.ovy = {16'b0, param_b_r[30:0]} >= {1'b0, p1_r.h[30:0], 15'b0};
    st2_nxt.x   = p1_r.x;
    st2_nxt.y   = p1_r.y;
    st2_nxt.w   = p1_r.w;
    st2_nxt.h   = p1_r.h;
    st2_nxt.sc  = p1_r.sc;
    if (adjust_mode_r == MODE_CROP) begin
      st2_nxt.sum_x = 33'(x1_s) + 33'(pa_s);
      st2_nxt.sum_y = 33'(y1_s) + 33'(pb_s);
      st2_nxt.sum_w = 34'(w1_s) - 34'(pa_s);
      st2_nxt.sum_h = 34'(h1_s) - 34'(pb_s);
    end else begin
      st2_nxt.sum_x = 33'(x1_s) - 33'(pa_s);
      st2_nxt.sum_y = 33'(y1_s) - 33'(pb_s);
      st2_nxt.sum_w = 34'(w1_s) + 34'(pa_s) + 34'(pc_s);
      st2_nxt.sum_h = 34'(h1_s) + 34'(pb_s) + 34'(pd_s);
    end
    st2_nxt.rot   = p1_r.rot;
    st2_nxt.rot_t = 27'($signed({2'b00, p1_r.rot})) + 27'($signed(rotation_delta_r));
    st2_nxt.cnt   = p1_r.cnt;
  end

  // ---------------- divider and matching delay line ----------------
  logic [DIV_QB-1:0] quot_x, quot_y;
  st2_t dly_r [DIV_QB];

  prect_div u_div_x (
    .clk    (clk),
    .en     (pipe_en),
    .num_i  (param_a_r[DIV_QB-1:0]),
    .den_i  (p1_r.w[DIV_QB-1:0]),
    .quot_o (quot_x)
  );

  prect_div u_div_y (
    .clk    (clk),
    .en     (pipe_en),
    .num_i  (param_b_r[DIV_QB-1:0]),
    .den_i  (p1_r.h[DIV_QB-1:0]),
    .quot_o (quot_y)
  );

  for (genvar g = 0; g < DIV_QB; g++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[g] <= 1'b0;
      end else if (pipe_en) begin
        vd_r[g] <= (g == 0) ? v1_r : vd_r[(g == 0) ? 0 : g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) dly_r[g] <= (g == 0) ? st2_nxt : dly_r[(g == 0) ? 0 : g-1];
    end
  end

  // ---------------- stage 3: mode select ----------------
  st2_t               d;
  st3_t               st3_nxt, p3_r;
  logic [DIV_QB-1:0]  sx, sy, sf;
  logic signed [26:0] rt;

  assign d  = dly_r[DIV_QB-1];
  assign sx = d.ovx ? '1 : quot_x;
  assign sy = d.ovy ? '1 : quot_y;
  assign sf = (adjust_mode_r == MODE_FIT) ? ((sx < sy) ? sx : sy) : ((sx > sy) ? sx : sy);
  assign rt = $signed(d.rot_t);

  always_comb begin
    st3_nxt.hit     = d.hit;
    st3_nxt.zero    = 1'b0;
    st3_nxt.mul_sel = 1'b0;
    st3_nxt.fa      = param_a_r;
    st3_nxt.fb      = param_b_r;
    st3_nxt.fc      = smin(param_a_r, param_b_r);
    st3_nxt.w       = d.w;
    st3_nxt.h       = d.h;
    st3_nxt.sc      = d.sc;
    st3_nxt.x_o     = d.x;
    st3_nxt.y_o     = d.y;
    st3_nxt.w_o     = d.w;
    st3_nxt.h_o     = d.h;
    st3_nxt.rot     = d.rot;
    st3_nxt.cnt     = d.cnt;
    if (d.hit) begin
      unique case (adjust_mode_r)
        MODE_SCALE: st3_nxt.mul_sel = 1'b1;
        MODE_CROP: begin
          if (d.crop_ok) begin
            st3_nxt.x_o  = sat33(d.sum_x);
            st3_nxt.y_o  = sat33(d.sum_y);
            st3_nxt.w_o  = smin(sat34(d.sum_w), param_c_r);
            st3_nxt.h_o  = smin(sat34(d.sum_h), param_d_r);
            st3_nxt.zero = ($signed(st3_nxt.w_o) <= 0) || ($signed(st3_nxt.h_o) <= 0);
          end
        end
        MODE_EXTEND: begin
          st3_nxt.x_o = sat33(d.sum_x);
          st3_nxt.y_o = sat33(d.sum_y);
          st3_nxt.w_o = sat34(d.sum_w);
          st3_nxt.h_o = sat34(d.sum_h);
        end
        MODE_FIT, MODE_FILL: begin
          if (d.fit_ok) begin
            st3_nxt.mul_sel = 1'b1;
            st3_nxt.fa      = {1'b0, sf};
            st3_nxt.fb      = {1'b0, sf};
            st3_nxt.fc      = {1'b0, sf};
          end
        end
        default: ;
      endcase
      // full-width delta plus an out-of-range input spans about -1.4 to 2.8 turns
      if (rotation_delta_r != '0) begin
        priority if (rt < -$signed(FULL_TURN))
          st3_nxt.rot = 25'(rt + $signed({FULL_TURN[25:0], 1'b0}));
        else if (rt < 0)
          st3_nxt.rot = 25'(rt + $signed(FULL_TURN));
        else if (rt < $signed(FULL_TURN))
          st3_nxt.rot = 25'(rt);
        else if (rt < $signed({FULL_TURN[25:0], 1'b0}))
          st3_nxt.rot = 25'(rt - $signed(FULL_TURN));
        else
          st3_nxt.rot = 25'(rt - $signed({FULL_TURN[25:0], 1'b0}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) p3_r <= st3_nxt;
  end

  // ---------------- stage 4: multiply ----------------
  st4_t p4_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p4_r.hit     <= p3_r.hit;
      p4_r.zero    <= p3_r.zero;
      p4_r.mul_sel <= p3_r.mul_sel;
      p4_r.pw      <= 64'($signed(p3_r.w))  * 64'($signed(p3_r.fa));
      p4_r.ph      <= 64'($signed(p3_r.h))  * 64'($signed(p3_r.fb));
      p4_r.ps      <= 64'($signed(p3_r.sc)) * 64'($signed(p3_r.fc));
      p4_r.x_o     <= p3_r.x_o;
      p4_r.y_o     <= p3_r.y_o;
      p4_r.w_o     <= p3_r.w_o;
      p4_r.h_o     <= p3_r.h_o;
      p4_r.sc      <= p3_r.sc;
      p4_r.rot     <= p3_r.rot;
      p4_r.cnt     <= p3_r.cnt;
    end
  end

  // ---------------- stage 5: round and assemble ----------------
  res_t res_nxt, p5_r;

  always_comb begin
    res_nxt.hit  = p4_r.hit;
    res_nxt.x    = p4_r.x_o;
    res_nxt.y    = p4_r.y_o;
    res_nxt.w    = p4_r.mul_sel ? qround(p4_r.pw) : p4_r.w_o;
    res_nxt.h    = p4_r.mul_sel ? qround(p4_r.ph) : p4_r.h_o;
    res_nxt.sc   = p4_r.mul_sel ? qround(p4_r.ps) : p4_r.sc;
    res_nxt.rot  = p4_r.rot;
    res_nxt.zero = p4_r.zero;
    res_nxt.cnt  = p4_r.cnt;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) p5_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_fire && in_cmd;
      v3_r <= vd_r[DIV_QB-1];
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // ---------------- output buffer ----------------
  logic pop, push;

  assign pop  = out_v_r && out_tready;
  assign push = v5_r && pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_r    <= skid_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
        if (push) out_r <= p5_r;
      end
    end else if (push) begin
      skid_r   <= p5_r;
      skid_v_r <= 1'b1;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, out_r.cnt, out_r.zero, out_r.rot, out_r.sc, out_r.h,
                       out_r.w, out_r.y, out_r.x, out_r.hit};

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while output register empty");

  a_zero_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.zero |-> out_r.hit)
    else $error("zero-area flag on an untargeted placement");

  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.hit && rotation_delta_r != '0 |-> {2'b00, out_r.rot} < FULL_TURN)
    else $error("rotation left outside one turn");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_cmd && hit_nxt |=> modified_count_r != '0)
    else $error("modified count did not advance");

endmodule
